// ===== sv/sorted_priority_queue_top_assert.svh =====
// Assertion macros for the sorted priority queue top level.
// Depends on signals clk and rst_n in the including module.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: command and status codes, entry type.
// No dependencies.
package spq_pkg;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_SORTED  = 2'd0;
    localparam cmd_t CMD_APPEND  = 2'd1;
    localparam cmd_t CMD_DEQUEUE = 2'd2;
    localparam cmd_t CMD_PEEK    = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] qty;
    } entry_t;

endpackage

// ===== sv/spq_ram.sv =====
// Entry store of the sorted priority queue: one write port, one registered read port.
// Depends on spq_pkg.
module spq_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  spq_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output spq_pkg::entry_t rd_data
);
    import spq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Top level of the sorted priority queue: command sequencer over a circular entry store.
// Depends on spq_pkg, spq_ram and sorted_priority_queue_top_assert.svh.
//
//   channel   dir  tdata                                   tuser
//   s_*       in   item_id[31:0], item_qty[47:32]          command[1:0]
//   m_*       out  out_id[31:0], out_qty[47:32],           status[1:0], has_item[2]
//                  count[52:48], zero pad[55:53]
//
// Append, full insert and empty dequeue/peek are answered from the idle state. Dequeue/peek
// take one store read. Sorted insert: scan from the front one entry a cycle to the
// insertion point p, shift count-p entries back one a cycle, then place; when the
// entry lands at the rear, it is written straight from the scan.
// Reset clears head and count; the store needs no clearing.
// s_tready drops while a command is in progress or a result waits on m_tready.
`include "sorted_priority_queue_top_assert.svh"

module sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_id, item_qty
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_id, out_qty, count, pad
    output logic [2:0]  m_tuser    // status, has_item
);
    import spq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_FRONT = 3'd4;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + (AW + 1)'(off);
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pos_reg, pos_next;
    cmd_t          cmd_reg, cmd_next;
    entry_t        item_reg, item_next;

    logic          m_tvalid_reg;
    status_t       out_status_reg;
    logic          out_has_reg;
    logic [31:0]   out_id_reg;
    logic [15:0]   out_qty_reg;
    logic [4:0]    out_count_reg;

    logic          accept;
    entry_t        in_entry;
    logic          full;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;
    logic          load;
    status_t       res_status;
    logic          res_has;
    entry_t        res_entry;
    logic [CW+4:0] count_ext;

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign in_entry = '{id: s_tdata[31:0], qty: s_tdata[47:32]};
    assign full     = (count_reg == DEPTH_C);

    spq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        item_next  = item_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = item_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        load       = 1'b0;
        res_status = ST_OK;
        res_has    = 1'b0;
        res_entry  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = s_tuser;
                    item_next = in_entry;
                    if (s_tuser inside {CMD_SORTED, CMD_APPEND})
                    begin
                        if (full)
                        begin
                            load       = 1'b1;
                            res_status = ST_FULL;
                        end
                        else if (s_tuser == CMD_APPEND || count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = wrap_add(head_reg, count_reg);
                            wr_data    = in_entry;
                            count_next = count_reg + ONE_C;
                            load       = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            k_next     = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            load       = 1'b1;
                            res_status = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_FRONT;
                        end
                    end
                end
            end
            S_FRONT:
            begin
                load       = 1'b1;
                res_has    = 1'b1;
                res_entry  = rd_data;
                state_next = S_IDLE;
                if (cmd_reg == CMD_DEQUEUE)
                begin
                    head_next  = wrap_add(head_reg, ONE_C);
                    count_next = count_reg - ONE_C;
                end
            end
            S_SCAN:
            begin
                if (item_reg.qty > rd_data.qty)
                begin
                    pos_next   = k_reg;
                    k_next     = count_reg - ONE_C;
                    rd_en      = 1'b1;
                    rd_addr    = wrap_add(head_reg, count_reg - ONE_C);
                    state_next = S_SHIFT;
                end
                else if (k_reg + ONE_C == count_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = wrap_add(head_reg, count_reg);
                    count_next = count_reg + ONE_C;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next  = k_reg + ONE_C;
                    rd_en   = 1'b1;
                    rd_addr = wrap_add(head_reg, k_reg + ONE_C);
                end
            end
            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_reg, k_reg + ONE_C);
                wr_data = rd_data;
                if (k_reg == pos_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    k_next  = k_reg - ONE_C;
                    rd_en   = 1'b1;
                    rd_addr = wrap_add(head_reg, k_reg - ONE_C);
                end
            end
            S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = wrap_add(head_reg, pos_reg);
                count_next = count_reg + ONE_C;
                load       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign count_ext = {5'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            pos_reg      <= '0;
            cmd_reg      <= CMD_SORTED;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            pos_reg   <= pos_next;
            cmd_reg   <= cmd_next;
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (load)
        begin
            out_status_reg <= res_status;
            out_has_reg    <= res_has;
            out_id_reg     <= res_entry.id;
            out_qty_reg    <= res_entry.qty;
            out_count_reg  <= count_ext[4:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_qty_reg, out_id_reg};
    assign m_tuser  = {out_has_reg, out_status_reg};

    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C)
    `SPQ_ASSERT_NOW(a_no_overwrite, load, !m_tvalid_reg || m_tready)
    `SPQ_ASSERT_NOW(a_shift_range, state_reg == S_SHIFT, (k_reg >= pos_reg) && (k_reg < count_reg))
    `SPQ_ASSERT_NEXT(a_front_read, accept && (s_tuser == CMD_DEQUEUE) && (count_reg != '0), state_reg == S_FRONT)

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for sorted_priority_queue_top: directed and random command streams
// checked against a scoreboard that keeps its own copy of the ordered store.
// Depends on spq_pkg and the sorted_priority_queue_top RTL.
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 400000;

    class queue_scoreboard;
        typedef struct {
            status_t     status;
            logic        has_item;
            logic [31:0] out_id;
            logic [15:0] out_qty;
            logic [4:0]  count;
        } response_t;

        entry_t    stored_entries[$];
        response_t pending_results[$];
        int        errors;
        int        depth;

        function new(int depth_value);
            depth  = depth_value;
            errors = 0;
        endfunction

        function void predict_command(cmd_t cmd, logic [31:0] id, logic [15:0] qty);
            response_t r;
            entry_t    e;
            int        pos;
            int        k;
            r.status   = ST_OK;
            r.has_item = 1'b0;
            r.out_id   = '0;
            r.out_qty  = '0;
            e.id       = id;
            e.qty      = qty;
            if (cmd == CMD_SORTED || cmd == CMD_APPEND)
            begin
                if (stored_entries.size() >= depth)
                    r.status = ST_FULL;
                else
                begin
                    pos = stored_entries.size();
                    if (cmd == CMD_SORTED)
                    begin
                        for (k = 0; k < stored_entries.size(); k++)
                        begin
                            if (qty > stored_entries[k].qty)
                            begin
                                pos = k;
                                break;
                            end
                        end
                    end
                    stored_entries.insert(pos, e);
                end
            end
            else if (stored_entries.size() == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.has_item = 1'b1;
                r.out_id   = stored_entries[0].id;
                r.out_qty  = stored_entries[0].qty;
                if (cmd == CMD_DEQUEUE)
                    void'(stored_entries.pop_front());
            end
            r.count = 5'(stored_entries.size());
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(logic [55:0] tdata, logic [2:0] tuser);
            response_t r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual tdata 0x%0h tuser 0x%0h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            r = pending_results.pop_front();
            compare_field("status", 32'(r.status), 32'(tuser[1:0]));
            compare_field("has_item", 32'(r.has_item), 32'(tuser[2]));
            compare_field("out_id", r.out_id, tdata[31:0]);
            compare_field("out_qty", 32'(r.out_qty), 32'(tdata[47:32]));
            compare_field("count", 32'(r.count), 32'(tdata[52:48]));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // item_id, item_qty
    logic [1:0]  s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // out_id, out_qty, count, pad
    logic [2:0]  m_tuser;   // status, has_item

    queue_scoreboard board;
    int              results_seen;
    int              cycle_count;

    sorted_priority_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hand one command over from a falling edge; return at the falling edge after it is accepted.
    task automatic send_command(input cmd_t cmd, input logic [31:0] id,
                                input logic [15:0] qty, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 99) < 10)
        begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {qty, id};
        s_tuser  = cmd;
        do
            @(posedge clk);
        while (!s_tready);
        board.predict_command(cmd, id, qty);
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_qty();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: pick_qty = 16'h0000;
            1: pick_qty = 16'hFFFF;
            2: pick_qty = 16'h8000;
            3: pick_qty = 16'($urandom_range(0, 3));
            default: pick_qty = 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random(input bit fill_bias, input bit may_idle);
        int   roll;
        cmd_t cmd;
        roll = $urandom_range(0, 99);
        if (fill_bias ? (roll < 70) : (roll < 30))
            cmd = ($urandom_range(0, 99) < 70) ? CMD_SORTED : CMD_APPEND;
        else
            cmd = ($urandom_range(0, 99) < 70) ? CMD_DEQUEUE : CMD_PEEK;
        send_command(cmd, $urandom, pick_qty(), may_idle);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (results_seen == 500)
            begin
                m_tready = 1'b0;
                repeat (300) @(negedge clk);
                m_tready = ($urandom_range(0, 99) >= 10);
            end
            else if (results_seen >= 150 && results_seen < 400)
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_response(m_tdata, m_tuser);
            results_seen++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int  i;
        bit  fill_bias;
        board        = new(DEPTH);
        results_seen = 0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_PEEK;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_command(CMD_PEEK, 32'h0, 16'h0, 1'b1);
        send_command(CMD_DEQUEUE, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
        send_command(CMD_SORTED, 32'h00000000, 16'h0000, 1'b1);
        send_command(CMD_SORTED, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
        send_command(CMD_SORTED, 32'h00000001, 16'h8000, 1'b1);
        send_command(CMD_SORTED, 32'h00000002, 16'h8000, 1'b1);
        send_command(CMD_APPEND, 32'h00000003, 16'hFFFF, 1'b1);
        send_command(CMD_SORTED, 32'h00000004, 16'h8000, 1'b1);
        send_command(CMD_PEEK, 32'h0, 16'h0, 1'b1);
        send_command(CMD_DEQUEUE, 32'h0, 16'h0, 1'b1);
        for (i = 0; i < 10; i++)
            send_command(i[0] ? CMD_APPEND : CMD_SORTED, $urandom, pick_qty(), 1'b1);
        send_command(CMD_SORTED, 32'hA5A5A5A5, 16'hFFFF, 1'b1);
        send_command(CMD_APPEND, 32'h5A5A5A5A, 16'h0000, 1'b1);
        send_command(CMD_PEEK, 32'h0, 16'h0, 1'b1);

        fill_bias = 1'b0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                fill_bias = ~fill_bias;
            if (i == 900)
            begin
                s_tvalid = 1'b0;
                while (board.pending_results.size() != 0)
                    @(negedge clk);
            end
            send_random(fill_bias, !(i >= 150 && i < 400));
        end
        s_tvalid = 1'b0;

        while (board.pending_results.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/spq_pkg.sv
sv/spq_ram.sv
sv/sorted_priority_queue_top.sv
tb/sv/testbench.sv
